// File: rtl/bmb_pkg.sv
// Shared types and codes for the bounded memory bus access block.
package bmb_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_LOAD  = 2'd1;
	localparam logic [1:0] FAULT_STORE = 2'd2;
	localparam logic [1:0] FAULT_RANGE = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE = 2'd3;

	localparam logic [31:0] MEM_BASE_RST = 32'd0;
	localparam logic [16:0] MEM_SIZE_RST = 17'd65536;
	localparam logic [31:0] RAM_BASE_RST = 32'd32768;
	localparam logic [16:0] RAM_SIZE_RST = 17'd32768;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  access_size;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  fault;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_t;

endpackage

// File: rtl/bmb_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface bmb_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/bmb_bank.sv
// One byte bank of the store: single port, registered read.
module bmb_bank #(
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bounded_memory_bus_access_top.sv
// Top level of the bounded memory bus access block.
//
//  channel  role   payload                                     handshake
//  req      sink   opcode, access_size, address, write_data    valid/ready
//  rsp      source read_data, fault                            valid/ready
//  cfg      sink   index, data                                 valid/ready (ready tied high)
//
// One access per cycle unless rsp stalls, through input and output stages.
// The store is four single-port byte banks, so an unaligned access of up to
// four bytes touches each bank at most once. Reset loads the window registers
// with their defaults and clears the pipeline valids; store contents stay
// undefined until written.
// A stalled rsp holds the output stage, then the input stage, then req.ready.
module bounded_memory_bus_access_top #(
	parameter int MEM_BYTES = 65536
) (
	input logic          clk,
	input logic          arst_n,
	bmb_stream_if.sink   req,
	bmb_stream_if.source rsp,
	bmb_stream_if.sink   cfg
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = AW - 2;
	localparam int BANK_DEPTH = MEM_BYTES / 4;
	localparam logic [33:0] STORE_LIM = 34'(MEM_BYTES);

	typedef struct packed {
		logic       rd_ok;
		logic [1:0] rot;
		logic [2:0] nbytes;
		logic [1:0] fault;
		logic [1:0] opcode;
	} rd_ctl_t;

	logic [31:0] mem_base_q;
	logic [16:0] mem_size_q;
	logic [31:0] ram_base_q;
	logic [16:0] ram_size_q;

	logic           v_s1;
	bmb_pkg::req_t  req_s1;
	logic           v_s2;
	rd_ctl_t        ctl_s2;
	logic           en1;
	logic           en2;
	logic           fire1;

	logic [2:0]     nbytes;
	logic [33:0]    a_ext;
	logic [33:0]    end_ext;
	logic [33:0]    esize;
	logic           rd_ok;
	logic           wr_ok;
	logic           ld_ok;
	logic           store_ok;
	logic [31:0]    off_full;
	logic [AW-1:0]  off;
	logic [1:0]     fault;
	rd_ctl_t        ctl_d;

	logic [3:0]          bank_we;
	logic [3:0][RW-1:0]  bank_addr;
	logic [3:0][7:0]     bank_wdata;
	logic [3:0][7:0]     bank_rdata;
	logic [31:0]         rdata;

	// Configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= bmb_pkg::MEM_BASE_RST;
			mem_size_q <= bmb_pkg::MEM_SIZE_RST;
			ram_base_q <= bmb_pkg::RAM_BASE_RST;
			ram_size_q <= bmb_pkg::RAM_SIZE_RST;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				bmb_pkg::REG_MEM_BASE: mem_base_q <= cfg.payload.data;
				bmb_pkg::REG_MEM_SIZE: mem_size_q <= cfg.payload.data[16:0];
				bmb_pkg::REG_RAM_BASE: ram_base_q <= cfg.payload.data;
				bmb_pkg::REG_RAM_SIZE: ram_size_q <= cfg.payload.data[16:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	assign en2   = !v_s2 || rsp.ready;
	assign en1   = !v_s1 || en2;
	assign fire1 = v_s1 && en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1 <= req.payload;
		end
		if (fire1) begin
			ctl_s2 <= ctl_d;
		end
	end

	// Window checks and bank steering
	always_comb begin
		case (req_s1.access_size)
			bmb_pkg::SIZE_BYTE: nbytes = 3'd1;
			bmb_pkg::SIZE_HALF: nbytes = 3'd2;
			default:            nbytes = 3'd4;
		endcase
		a_ext   = {2'b00, req_s1.address};
		end_ext = a_ext + 34'(nbytes);
		esize   = (34'(mem_size_q) < STORE_LIM) ? 34'(mem_size_q) : STORE_LIM;
		rd_ok   = (a_ext >= 34'(mem_base_q)) && (end_ext <= 34'(mem_base_q) + esize);
		wr_ok   = (a_ext >= 34'(ram_base_q))
			&& (end_ext <= 34'(ram_base_q) + 34'(ram_size_q))
			&& (a_ext >= 34'(mem_base_q))
			&& (end_ext <= 34'(mem_base_q) + STORE_LIM);
		ld_ok   = end_ext <= STORE_LIM;

		case (req_s1.opcode)
			bmb_pkg::OP_READ:  fault = rd_ok ? bmb_pkg::FAULT_NONE : bmb_pkg::FAULT_LOAD;
			bmb_pkg::OP_WRITE: fault = wr_ok ? bmb_pkg::FAULT_NONE : bmb_pkg::FAULT_STORE;
			bmb_pkg::OP_LOAD:  fault = ld_ok ? bmb_pkg::FAULT_NONE : bmb_pkg::FAULT_RANGE;
			default:           fault = bmb_pkg::FAULT_NONE;
		endcase

		store_ok = ((req_s1.opcode == bmb_pkg::OP_WRITE) && wr_ok)
			|| ((req_s1.opcode == bmb_pkg::OP_LOAD) && ld_ok);
		off_full = (req_s1.opcode == bmb_pkg::OP_LOAD) ? req_s1.address
			: req_s1.address - mem_base_q;
		off = off_full[AW-1:0];

		ctl_d.rd_ok  = (req_s1.opcode == bmb_pkg::OP_READ) && rd_ok;
		ctl_d.rot    = off[1:0];
		ctl_d.nbytes = nbytes;
		ctl_d.fault  = fault;
		ctl_d.opcode = req_s1.opcode;
	end

	always_comb begin
		logic [1:0]  idx;
		logic [31:0] sh;
		for (int b = 0; b < 4; b++) begin
			idx = 2'(b) - off[1:0];
			sh  = req_s1.write_data >> {idx, 3'b000};
			bank_we[b]    = fire1 && store_ok && ({1'b0, idx} < nbytes);
			bank_addr[b]  = off[AW-1:2] + RW'(2'(b) < off[1:0]);
			bank_wdata[b] = sh[7:0];
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		bmb_bank #(
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.en   (fire1),
			.we   (bank_we[g]),
			.addr (bank_addr[g]),
			.wdata(bank_wdata[g]),
			.rdata(bank_rdata[g])
		);
	end

	// Result assembly
	always_comb begin
		logic [1:0] bi;
		rdata = '0;
		for (int i = 0; i < 4; i++) begin
			bi = ctl_s2.rot + 2'(i);
			if (ctl_s2.rd_ok && (3'(i) < ctl_s2.nbytes)) begin
				rdata[8*i +: 8] = bank_rdata[bi];
			end
		end
	end

	assign rsp.valid             = v_s2;
	assign rsp.payload.read_data = rdata;
	assign rsp.payload.fault     = ctl_s2.fault;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.payload.fault != bmb_pkg::FAULT_NONE)
		|-> rsp.payload.read_data == 32'd0)
		else $error("faulting beat carries nonzero read data");

	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (ctl_s2.opcode != bmb_pkg::OP_READ)
		|-> rsp.payload.read_data == 32'd0)
		else $error("non-read beat carries read data");

	a_we_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_we != 4'd0) |-> fire1 && (req_s1.opcode != bmb_pkg::OP_READ))
		else $error("bank write outside a moving store beat");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !v_s1 || en2)
		else $error("request accepted over a held stage");

	a_fault_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && (fault != bmb_pkg::FAULT_NONE) |-> bank_we == 4'd0)
		else $error("faulting access wrote the store");

endmodule

// File: verif/bounded_memory_bus_access_top_test.sv
// Testbench for the bounded memory bus access block: predicted results against DUT beats.
module bounded_memory_bus_access_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MEM_BYTES   = 65536;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          RECENT_CAP  = 64;
	localparam logic [1:0]  OP_RSVD     = 2'd3;
	localparam logic [1:0]  SIZE_WORD   = 2'd2;
	localparam logic [1:0]  SIZE_RSVD   = 2'd3;

	typedef struct {
		bmb_pkg::req_t acc;
		bit            typed;
		bmb_pkg::rsp_t want;
	} probe_t;

	logic clk;
	logic arst_n;

	bmb_stream_if #(.payload_t(bmb_pkg::req_t)) req_ch ();
	bmb_stream_if #(.payload_t(bmb_pkg::rsp_t)) rsp_ch ();
	bmb_stream_if #(.payload_t(bmb_pkg::cfg_t)) cfg_ch ();

	bounded_memory_bus_access_top #(
		.MEM_BYTES(MEM_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// expected results in acceptance order
	bmb_pkg::rsp_t expected_rsp [$];
	logic [7:0]    store_img [0:MEM_BYTES-1];
	bit            written [0:MEM_BYTES-1];
	int            recent_off [$];
	logic [31:0]   w_mem_base;
	logic [16:0]   w_mem_size;
	logic [31:0]   w_ram_base;
	logic [16:0]   w_ram_size;

	int  errors;
	int  cycles;
	int  accesses;
	int  checked;
	int  read_hits;
	int  fault_tally [0:3];
	int  holdoff_asked;
	int  holdoff_done;
	bit  idle_en;

	logic [31:0] fill_offs [0:2] = '{32'h0000_0000, 32'h0000_0100, 32'h0000_FFFC};

	probe_t probes [0:24] = '{
		'{'{bmb_pkg::OP_READ,  bmb_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  SIZE_WORD, 32'h0000_FFFC, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  SIZE_WORD, 32'h0000_FFFD, 32'h0}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_LOAD}},
		'{'{bmb_pkg::OP_READ,  bmb_pkg::SIZE_BYTE, 32'h0001_0000, 32'h0}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_LOAD}},
		'{'{bmb_pkg::OP_READ,  bmb_pkg::SIZE_HALF, 32'h0000_FFFF, 32'h0}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_LOAD}},
		'{'{bmb_pkg::OP_WRITE, SIZE_WORD, 32'h0000_8000, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  SIZE_WORD, 32'h0000_8000, 32'h0}, 1'b1,
			'{32'hFFFF_FFFF, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_WRITE, SIZE_WORD, 32'h0000_7FFF, 32'h1111_1111}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_STORE}},
		'{'{bmb_pkg::OP_WRITE, bmb_pkg::SIZE_BYTE, 32'h0000_7FFF, 32'h0000_00AA}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_STORE}},
		'{'{bmb_pkg::OP_WRITE, SIZE_WORD, 32'h0000_FFFC, 32'h0000_0000}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_WRITE, SIZE_WORD, 32'h0000_FFFD, 32'h2222_2222}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_STORE}},
		'{'{bmb_pkg::OP_WRITE, bmb_pkg::SIZE_HALF, 32'h0000_8001, 32'h0000_A5C3}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  SIZE_WORD, 32'h0000_8000, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_WRITE, SIZE_WORD, 32'h0000_8003, 32'h1234_5678}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  bmb_pkg::SIZE_HALF, 32'h0000_8005, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_LOAD,  SIZE_WORD, 32'h0000_FFFC, 32'hDEAD_BEEF}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_LOAD,  SIZE_WORD, 32'h0000_FFFD, 32'h3333_3333}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_RANGE}},
		'{'{bmb_pkg::OP_LOAD,  bmb_pkg::SIZE_BYTE, 32'h0000_FFFF, 32'h0000_005A}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_LOAD,  bmb_pkg::SIZE_HALF, 32'h0000_FFFF, 32'h0000_4444}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_RANGE}},
		'{'{bmb_pkg::OP_LOAD,  bmb_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_0055}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_RANGE}},
		'{'{bmb_pkg::OP_READ,  SIZE_WORD, 32'h0000_FFFC, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{OP_RSVD,           SIZE_WORD, 32'h0000_8000, 32'h7777_7777}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_READ,  SIZE_RSVD, 32'h0000_0100, 32'h0}, 1'b0,
			'{32'h0, bmb_pkg::FAULT_NONE}},
		'{'{bmb_pkg::OP_WRITE, SIZE_RSVD, 32'hFFFF_FFFF, 32'h8888_8888}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_STORE}},
		'{'{bmb_pkg::OP_READ,  bmb_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'h0}, 1'b1,
			'{32'h0, bmb_pkg::FAULT_LOAD}}
	};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_rsp.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic bit fits(longint unsigned a, longint unsigned n,
		longint unsigned base, longint unsigned span);
		return a >= base && a + n <= base + span;
	endfunction

	function automatic longint unsigned access_bytes(input logic [1:0] size);
		return (size == bmb_pkg::SIZE_BYTE) ? 1 : (size == bmb_pkg::SIZE_HALF) ? 2 : 4;
	endfunction

	function automatic void note_written(input int off);
		recent_off.push_back(off);
		if (recent_off.size() > RECENT_CAP)
			void'(recent_off.pop_front());
	endfunction

	// a read that lands in the window must only touch bytes already written
	function automatic bit reads_unwritten(input bmb_pkg::req_t acc);
		longint unsigned a;
		longint unsigned n;
		longint unsigned esize;
		a = acc.address;
		n = access_bytes(acc.access_size);
		esize = (w_mem_size < MEM_BYTES) ? w_mem_size : MEM_BYTES;
		if (acc.opcode != bmb_pkg::OP_READ || !fits(a, n, w_mem_base, esize))
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (!written[int'(a - w_mem_base + i)])
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic predict_access(input bmb_pkg::req_t acc, output bmb_pkg::rsp_t res);
		longint unsigned a;
		longint unsigned n;
		longint unsigned off;
		longint unsigned esize;
		res = '0;
		a = acc.address;
		n = access_bytes(acc.access_size);
		case (acc.opcode)
			bmb_pkg::OP_READ: begin
				esize = (w_mem_size < MEM_BYTES) ? w_mem_size : MEM_BYTES;
				if (fits(a, n, w_mem_base, esize)) begin
					off = a - w_mem_base;
					for (int i = 0; i < n; i++)
						res.read_data[8*i +: 8] = store_img[int'((off + i) % MEM_BYTES)];
					read_hits++;
				end else begin
					res.fault = bmb_pkg::FAULT_LOAD;
				end
			end
			bmb_pkg::OP_WRITE: begin
				if (fits(a, n, w_ram_base, w_ram_size) && fits(a, n, w_mem_base, MEM_BYTES)) begin
					off = a - w_mem_base;
					for (int i = 0; i < n; i++) begin
						store_img[int'((off + i) % MEM_BYTES)] = acc.write_data[8*i +: 8];
						written[int'((off + i) % MEM_BYTES)] = 1'b1;
					end
					note_written(int'(off % MEM_BYTES));
				end else begin
					res.fault = bmb_pkg::FAULT_STORE;
				end
			end
			bmb_pkg::OP_LOAD: begin
				if (a + n <= MEM_BYTES) begin
					for (int i = 0; i < n; i++) begin
						store_img[int'(a + i)] = acc.write_data[8*i +: 8];
						written[int'(a + i)] = 1'b1;
					end
					note_written(int'(a));
				end else begin
					res.fault = bmb_pkg::FAULT_RANGE;
				end
			end
			default: ;
		endcase
		fault_tally[res.fault]++;
	endtask

	task automatic send_access(input bmb_pkg::req_t acc, input bit typed,
		input bmb_pkg::rsp_t want);
		bmb_pkg::rsp_t pred;
		while (idle_en && $urandom_range(0, 99) < 14) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= acc;
		do @(negedge clk); while (!req_ch.ready);
		predict_access(acc, pred);
		expected_rsp.push_back(typed ? want : pred);
		accesses++;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [bmb_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		bmb_pkg::cfg_t beat;
		beat.index = idx;
		beat.data  = value;
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= beat;
		do @(negedge clk); while (!cfg_ch.ready);
		case (idx)
			bmb_pkg::REG_MEM_BASE: w_mem_base = value;
			bmb_pkg::REG_MEM_SIZE: w_mem_size = value[16:0];
			bmb_pkg::REG_RAM_BASE: w_ram_base = value;
			bmb_pkg::REG_RAM_SIZE: w_ram_size = value[16:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_windows(input logic [31:0] mb, input logic [16:0] ms,
		input logic [31:0] rb, input logic [16:0] rs);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
		write_reg(bmb_pkg::REG_MEM_BASE, mb);
		write_reg(bmb_pkg::REG_MEM_SIZE, {15'd0, ms});
		write_reg(bmb_pkg::REG_RAM_BASE, rb);
		write_reg(bmb_pkg::REG_RAM_SIZE, {15'd0, rs});
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic bmb_pkg::req_t random_access();
		bmb_pkg::req_t acc;
		logic [31:0]   base;
		logic [16:0]   span;
		int            pick;
		pick = $urandom_range(0, 19);
		acc.opcode = (pick < 8) ? bmb_pkg::OP_READ : (pick < 15) ? bmb_pkg::OP_WRITE :
			(pick < 19) ? bmb_pkg::OP_LOAD : OP_RSVD;
		pick = $urandom_range(0, 9);
		acc.access_size = (pick < 3) ? bmb_pkg::SIZE_BYTE : (pick < 6) ? bmb_pkg::SIZE_HALF :
			(pick < 9) ? SIZE_WORD : SIZE_RSVD;
		acc.write_data = $urandom;
		if (acc.opcode == bmb_pkg::OP_LOAD) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: acc.address = $urandom_range(0, MEM_BYTES - 1);
				6, 7, 8: acc.address = MEM_BYTES - $urandom_range(0, 6);
				default: acc.address = $urandom;
			endcase
		end else if (acc.opcode == bmb_pkg::OP_READ && recent_off.size() != 0
			&& $urandom_range(0, 1) == 0) begin
			acc.address = w_mem_base
				+ 32'(recent_off[$urandom_range(0, recent_off.size() - 1)]);
		end else begin
			if ((acc.opcode == bmb_pkg::OP_WRITE) ^ ($urandom_range(0, 3) == 0)) begin
				base = w_ram_base;
				span = w_ram_size;
			end else begin
				base = w_mem_base;
				span = w_mem_size;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: acc.address = base + ((span == 0) ? 0 : $urandom_range(0, span - 1));
				5, 6: acc.address = base + span - $urandom_range(0, 5);
				7: acc.address = base - $urandom_range(0, 3);
				8: acc.address = w_mem_base + MEM_BYTES - $urandom_range(0, 5);
				default: acc.address = $urandom_range(0, 1) ? $urandom :
					32'hFFFF_FFFF - $urandom_range(0, 5);
			endcase
		end
		// a read of unwritten bytes is sent instead as a loader write of those bytes
		if (reads_unwritten(acc)) begin
			acc.opcode  = bmb_pkg::OP_LOAD;
			acc.address = acc.address - w_mem_base;
		end
		return acc;
	endfunction

	task automatic random_run(input int count);
		for (int k = 0; k < count; k++)
			send_access(random_access(), 1'b0, '0);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_asked != holdoff_done) begin
				holdoff_done++;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ch.ready <= !(idle_en && $urandom_range(0, 99) < 14);
		end
	end

	initial begin
		bmb_pkg::rsp_t got;
		bmb_pkg::rsp_t want;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("unexpected beat data %h fault %0d",
						got.read_data, got.fault));
				end else begin
					want = expected_rsp.pop_front();
					if (got.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, predicted %h",
							got.read_data, want.read_data));
					if (got.fault !== want.fault)
						report_mismatch($sformatf("fault %0d, predicted %0d",
							got.fault, want.fault));
				end
				checked++;
			end
		end
	end

	initial begin
		bmb_pkg::req_t fill;
		arst_n         = 1'b0;
		idle_en        = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.payload = '0;
		w_mem_base     = bmb_pkg::MEM_BASE_RST;
		w_mem_size     = bmb_pkg::MEM_SIZE_RST;
		w_ram_base     = bmb_pkg::RAM_BASE_RST;
		w_ram_size     = bmb_pkg::RAM_SIZE_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// seed the words that the directed reads touch, no idling until the first random run ends
		foreach (fill_offs[i]) begin
			fill.opcode      = bmb_pkg::OP_LOAD;
			fill.access_size = SIZE_WORD;
			fill.address     = fill_offs[i];
			fill.write_data  = $urandom;
			send_access(fill, 1'b0, '0);
		end

		foreach (probes[i])
			send_access(probes[i].acc, probes[i].typed, probes[i].want);
		random_run(80);
		idle_en = 1'b1;

		set_windows(32'h0000_0000, 17'd65536, 32'h0000_0000, 17'd65536);
		holdoff_asked++;
		random_run(80);

		set_windows(32'h1000_0000, 17'h0_8000, 32'h1000_4000, 17'h0_4000);
		random_run(80);

		set_windows(32'hFFFF_0000, 17'd65536, 32'hFFFF_C000, 17'd65536);
		random_run(70);

		set_windows(32'h0000_2000, 17'h1_FFFF, 32'h0000_1000, 17'h1_FFFF);
		random_run(70);

		set_windows(32'hFFFF_FFFF, 17'd0, 32'hFFFF_FFFF, 17'd0);
		random_run(40);

		set_windows(32'hFFFF_FFFC, 17'd4, 32'hFFFF_FFFC, 17'd4);
		random_run(50);

		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d accesses over seven window settings: %0d read hits", accesses,
			read_hits);
		$display("faults load/store/range %0d/%0d/%0d, %0d beats checked, %0d mismatches",
			fault_tally[bmb_pkg::FAULT_LOAD], fault_tally[bmb_pkg::FAULT_STORE],
			fault_tally[bmb_pkg::FAULT_RANGE], checked, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: bounded_memory_bus_access_top.f
rtl/bmb_pkg.sv
rtl/bmb_stream_if.sv
rtl/bmb_bank.sv
rtl/bounded_memory_bus_access_top.sv
verif/bounded_memory_bus_access_top_test.sv
